// ===== rtl/e2d_pkg.sv =====
package e2d_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int EW         = FRAC_BITS + 2;
  localparam int STEPS      = 30;
  localparam int CORD_FRAC  = 30;
  localparam int CW         = 34;
  localparam int PW         = 2 * EW + 2;

  localparam logic signed [CW-1:0] GAIN_INV = CW'(652032874);
  localparam logic signed [EW-1:0] ONE      = EW'(1 << FRAC_BITS);

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cord_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  flip;
    cord_t [2:0] c;
  } stage_t;

  function automatic logic signed [CW-1:0] atan_tab(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;
      5'd29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return CW'(signed'({1'b0, v}));
  endfunction

  // round half up by FRAC_BITS, saturate to +-1.0
  function automatic logic signed [EW-1:0] rnd_sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = (v + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (t > PW'(ONE)) return ONE;
    if (t < -PW'(ONE)) return -ONE;
    return EW'(t);
  endfunction

  function automatic logic signed [EW-1:0] cord_rnd(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    t = (v + (CW'(1) <<< (CORD_FRAC - FRAC_BITS - 1))) >>> (CORD_FRAC - FRAC_BITS);
    if (t > CW'(ONE)) return ONE;
    if (t < -CW'(ONE)) return -ONE;
    return EW'(t);
  endfunction

endpackage

// ===== rtl/e2d_cell.sv =====
module e2d_cell
  import e2d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       ce,
  input  logic [4:0] step,
  input  stage_t     din,
  output stage_t     dout
);

  stage_t nxt;

  always_comb begin
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    nxt = din;
    for (int k = 0; k < 3; k++) begin
      dx = din.c[k].y >>> step;
      dy = din.c[k].x >>> step;
      if (!din.c[k].z[CW-1]) begin
        nxt.c[k].x = din.c[k].x - dx;
        nxt.c[k].y = din.c[k].y + dy;
        nxt.c[k].z = din.c[k].z - atan_tab(step);
      end else begin
        nxt.c[k].x = din.c[k].x + dx;
        nxt.c[k].y = din.c[k].y - dy;
        nxt.c[k].z = din.c[k].z + atan_tab(step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dout.flip <= nxt.flip;
      dout.c    <= nxt.c;
    end
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (ce) begin
      dout.valid <= nxt.valid;
    end
  end

endmodule

// ===== rtl/e2d_mat.sv =====
module e2d_mat
  import e2d_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 ce,
  input  stage_t               din,
  output logic                 valid,
  output logic signed [EW-1:0] r [9]
);

  // stage 1: sine/cosine
  logic                 v1;
  logic signed [EW-1:0] sn [3];
  logic signed [EW-1:0] cs [3];
  // stage 2: first products
  logic                 v2;
  logic signed [EW-1:0] stc, sts, e0, e1, e2, e5, e8;
  logic signed [EW-1:0] sf2, cf2, sp2, cp2;
  // stage 3: second products
  logic                 v3;
  logic signed [PW-1:0] p [8];
  logic signed [EW-1:0] e0_3, e1_3, e2_3, e5_3, e8_3;

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        cs[k] <= cord_rnd(din.flip[k] ? -din.c[k].x : din.c[k].x);
        sn[k] <= cord_rnd(din.flip[k] ? -din.c[k].y : din.c[k].y);
      end
      stc <= rnd_sat(PW'(sn[1]) * PW'(cs[2]));
      sts <= rnd_sat(PW'(sn[1]) * PW'(sn[2]));
      e0  <= rnd_sat(PW'(cs[1]) * PW'(cs[2]));
      e1  <= rnd_sat(PW'(cs[1]) * PW'(sn[2]));
      e2  <= (-sn[1] > ONE) ? ONE : -sn[1];
      e5  <= rnd_sat(PW'(sn[0]) * PW'(cs[1]));
      e8  <= rnd_sat(PW'(cs[0]) * PW'(cs[1]));
      sf2 <= sn[0];
      cf2 <= cs[0];
      sp2 <= sn[2];
      cp2 <= cs[2];
      p[0] <= -(PW'(cf2) * PW'(sp2));
      p[1] <= PW'(sf2) * PW'(stc);
      p[2] <= PW'(cf2) * PW'(cp2);
      p[3] <= PW'(sf2) * PW'(sts);
      p[4] <= PW'(sf2) * PW'(sp2);
      p[5] <= PW'(cf2) * PW'(stc);
      p[6] <= -(PW'(sf2) * PW'(cp2));
      p[7] <= PW'(cf2) * PW'(sts);
      e0_3 <= e0;
      e1_3 <= e1;
      e2_3 <= e2;
      e5_3 <= e5;
      e8_3 <= e8;
      r[0] <= e0_3;
      r[1] <= e1_3;
      r[2] <= e2_3;
      r[3] <= rnd_sat(p[0] + p[1]);
      r[4] <= rnd_sat(p[2] + p[3]);
      r[5] <= e5_3;
      r[6] <= rnd_sat(p[4] + p[5]);
      r[7] <= rnd_sat(p[6] + p[7]);
      r[8] <= e8_3;
    end
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      valid <= 1'b0;
    end else if (ce) begin
      v1    <= din.valid;
      v2    <= v1;
      v3    <= v2;
      valid <= v3;
    end
  end

endmodule

// ===== rtl/euler_to_dcm_core.sv =====
// channel | dir | width | fields (lsb first)
// s_axis  | in  | 48    | roll_angle, pitch_angle, yaw_angle
// m_axis  | out | 144   | m_r0_c0 .. m_r2_c2, row-major
//
// One item per cycle while the output is not stalled; the pipe is 30 CORDIC cells then 4 matrix stages.
// The CORDIC cell row sets the depth; the matrix stages set the multiplier count.
// rst clears all valid flags; payload registers are not reset.
// A stalled output holds the whole pipe; s_tready = !m_tvalid | m_tready.
module euler_to_dcm_core
  import e2d_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [3*ANGLE_BITS-1:0] s_tdata,   // roll_angle, pitch_angle, yaw_angle
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [9*EW-1:0]         m_tdata    // m_r0_c0, m_r0_c1, ... m_r2_c2
);

  logic                 ce;
  stage_t               chain [STEPS+1];
  logic signed [EW-1:0] r [9];

  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  always_comb begin
    logic [31:0] a;
    logic [31:0] t;
    logic        f;
    chain[0].valid = s_tvalid;
    for (int k = 0; k < 3; k++) begin
      a = {s_tdata[ANGLE_BITS*k +: ANGLE_BITS], {(32-ANGLE_BITS){1'b0}}};
      t = a + 32'h40000000;
      f = t[31];
      chain[0].flip[k] = f;
      chain[0].c[k].x  = GAIN_INV;
      chain[0].c[k].y  = '0;
      chain[0].c[k].z  = CW'(signed'({a[31] ^ f, a[30:0]}));
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    e2d_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ce   (ce),
      .step (5'(i)),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  e2d_mat u_mat (
    .clk   (clk),
    .rst   (rst),
    .ce    (ce),
    .din   (chain[STEPS]),
    .valid (m_tvalid),
    .r     (r)
  );

  for (genvar j = 0; j < 9; j++) begin : g_out
    assign m_tdata[EW*j +: EW] = r[j];
  end

`ifndef SYNTH
  a_rst_clear: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("ready mismatch");
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(r[8]) <= ONE && $signed(r[8]) >= -ONE))
    else $error("element out of range");
`endif

endmodule
